@@ hdl/frdpt_pkg.sv @@
package frdpt_pkg;

    // default parameter values
    localparam int DEF_RATE_FRAC_BITS    = 10;
    localparam int DEF_PERIOD_FRAC_BITS  = 16;
    localparam int DEF_MAX_DISPLAY_STEPS = 65535;

    localparam int CFG_W  = 20;
    localparam int TIME_W = 63;
    localparam int SKIP_W = 16;
    localparam int ADDR_W = 4;

    localparam logic [CFG_W-1:0] DISPLAY_RATE_RST = 20'd61440;
    localparam logic [CFG_W-1:0] TARGET_RATE_RST  = 20'd61440;

    localparam logic [63:0] NS_PER_S = 64'd1000000000;
    localparam logic [15:0] MAX_CORR = 16'd50000;
    localparam logic [15:0] SKIP_MAX = 16'hffff;
    localparam logic [7:0]  CORR_DIV = 8'd50;
    localparam logic [7:0]  CORR_BIAS = 8'd25;

    // x / 50 as (x * CORR_RECIP) >> CORR_SHIFT, exact for x below 2^22
    localparam logic [22:0] CORR_RECIP = 23'd5368710;
    localparam int          CORR_SHIFT = 28;

    // register indexes
    localparam logic [1:0] REG_DISPLAY_RATE = 2'd0;
    localparam logic [1:0] REG_TARGET_RATE  = 2'd1;
    localparam logic [1:0] REG_ENABLE       = 2'd2;

    // shared divider operations
    localparam logic [2:0] DIV_DPER  = 3'd0;
    localparam logic [2:0] DIV_TPER  = 3'd1;
    localparam logic [2:0] DIV_STEPS = 3'd2;
    localparam logic [2:0] DIV_SEL   = 3'd3;

    typedef struct packed {
        logic       in_ready;
        logic       load_rates;
        logic       div_start;
        logic [2:0] div_op;
        logic       dpq_load;
        logic       tpq_load;
        logic       clr_fin;
        logic       steps_one;
        logic       steps_load;
        logic       mul_acc;
        logic       acc_add;
        logic       sel_load;
        logic       set_ideal_t;
        logic       adv_mul;
        logic       adv_add;
        logic       err_load;
        logic       corr_apply;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic cfg_clr;
        logic in_fire;
        logic enable;
        logic need_div;
        logic div_done;
        logic acc_ge;
        logic first_sel;
        logic big_err;
        logic out_free;
    } sts_t;

endpackage

@@ hdl/frdpt_in_if.sv @@
interface frdpt_in_if
    import frdpt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] refresh_time;

    modport source (output valid, output refresh_time, input ready);
    modport sink (input valid, input refresh_time, output ready);
endinterface

@@ hdl/frdpt_out_if.sv @@
interface frdpt_out_if
    import frdpt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] selected_time;
    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] presentation_time;
    logic [SKIP_W-1:0] skipped_frames;

    modport source (output valid, output selected_time, output interval,
                    output presentation_time, output skipped_frames, input ready);
    modport sink (input valid, input selected_time, input interval,
                  input presentation_time, input skipped_frames, output ready);
endinterface

@@ hdl/frdpt_div.sv @@
module frdpt_div
    import frdpt_pkg::*;
#(
    parameter int NUM_W = 79,
    parameter int DEN_W = 47
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             qbit;

    // one restoring step per cycle, msb first
    always_comb
    begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        qbit  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], qbit};
            rem_reg <= qbit ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;
    assign rem  = rem_reg;
endmodule

@@ hdl/frdpt_dp.sv @@
module frdpt_dp
    import frdpt_pkg::*;
#(
    parameter int RATE_FRAC_BITS    = DEF_RATE_FRAC_BITS,
    parameter int PERIOD_FRAC_BITS  = DEF_PERIOD_FRAC_BITS,
    parameter int MAX_DISPLAY_STEPS = DEF_MAX_DISPLAY_STEPS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    frdpt_in_if.sink          in_ch,
    frdpt_out_if.source       out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata
);
    localparam int RF     = RATE_FRAC_BITS;
    localparam int PF     = PERIOD_FRAC_BITS;
    localparam int RATE_W = (RF + 10 > CFG_W) ? RF + 10 : CFG_W;
    localparam int STEP_W = $clog2(MAX_DISPLAY_STEPS + 1);
    localparam int SEL_W  = STEP_W + 1;
    localparam int ACC_W  = RATE_W + STEP_W + 1;
    localparam int PER_W  = PF + 31;
    localparam int INT_W  = PER_W - PF;
    localparam int FR_W   = (PF > 0) ? PF : 1;
    localparam int PI_W   = INT_W + SEL_W;
    localparam int PFR_W  = FR_W + SEL_W;
    localparam int DIV_W  = (63 + PF > 30 + PF + RF) ? 63 + PF : 30 + PF + RF;
    localparam int HALF   = (PF > 0) ? (1 << (PF - 1)) : 0;
    localparam logic [FR_W-1:0] FMASK = (PF > 0) ? FR_W'((64'd1 << PF) - 64'd1) : '0;
    localparam logic [RATE_W-1:0] RATE_LO  = RATE_W'(64'd24 << RF);
    localparam logic [RATE_W-1:0] RATE_HI  = RATE_W'(64'd1000 << RF);
    localparam logic [RATE_W-1:0] RATE_DEF = RATE_W'(64'd60 << RF);
    localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(64'd1 << RF);
    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(MAX_DISPLAY_STEPS);
    localparam logic [63:0]       CORR_SAT = 64'(MAX_CORR) * 64'(CORR_DIV);

    // configuration registers
    logic [CFG_W-1:0] disp_raw_reg;
    logic [CFG_W-1:0] targ_raw_reg;
    logic             enable_reg;
    logic             cfg_wr;

    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_raw_reg <= DISPLAY_RATE_RST;
            targ_raw_reg <= TARGET_RATE_RST;
            enable_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_DISPLAY_RATE: disp_raw_reg <= pwdata[CFG_W-1:0];
                REG_TARGET_RATE:  targ_raw_reg <= pwdata[CFG_W-1:0];
                REG_ENABLE:       enable_reg   <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_DISPLAY_RATE: prdata = 32'(disp_raw_reg);
            REG_TARGET_RATE:  prdata = 32'(targ_raw_reg);
            REG_ENABLE:       prdata = 32'(enable_reg);
            default:          prdata = '0;
        endcase
    end

    // rate sanitizing
    logic [RATE_W-1:0] disp_san;
    logic [RATE_W-1:0] targ_san;
    logic [RATE_W-1:0] targ_lo;

    always_comb
    begin
        disp_san = RATE_W'(disp_raw_reg);
        if (disp_san < RATE_LO || disp_san > RATE_HI)
            disp_san = RATE_DEF;
        targ_lo = RATE_W'(targ_raw_reg);
        if (targ_lo < RATE_ONE)
            targ_lo = RATE_ONE;
        targ_san = (targ_lo > disp_san) ? disp_san : targ_lo;
    end

    // datapath registers
    logic [RATE_W-1:0] dq_reg;
    logic [RATE_W-1:0] tq_reg;
    logic [PER_W-1:0]  dpq_reg;
    logic [PER_W-1:0]  tpq_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  prod_reg;
    logic [STEP_W-1:0] steps_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic [TIME_W-1:0] t_reg;
    logic [TIME_W-1:0] last_ref_reg;
    logic [TIME_W-1:0] last_sel_reg;
    logic [TIME_W-1:0] ival_reg;
    logic [63:0]       ideal_reg;
    logic [63:0]       err_reg;
    logic              neg_reg;
    logic [PI_W-1:0]   pint_reg;
    logic [PFR_W-1:0]  pfrac_reg;
    logic              ref_valid_reg;
    logic              sel_valid_reg;
    logic              out_valid_reg;
    logic [TIME_W-1:0] o_sel_reg;
    logic [TIME_W-1:0] o_ival_reg;
    logic [TIME_W-1:0] o_pres_reg;
    logic [SKIP_W-1:0] o_skip_reg;

    // shared divider
    logic [DIV_W-1:0] div_num;
    logic [PER_W-1:0] div_den;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic [PER_W-1:0] div_rem;
    logic             div_rnd;
    logic [DIV_W:0]   quo_rnd;

    always_comb
    begin
        case (cmd.div_op)
            DIV_DPER:
            begin
                div_num = DIV_W'(NS_PER_S) << (PF + RF);
                div_den = PER_W'(dq_reg);
            end
            DIV_TPER:
            begin
                div_num = DIV_W'(NS_PER_S) << (PF + RF);
                div_den = PER_W'(tq_reg);
            end
            DIV_STEPS:
            begin
                div_num = DIV_W'(t_reg - last_ref_reg) << PF;
                div_den = dpq_reg;
            end
            DIV_SEL:
            begin
                div_num = DIV_W'(acc_reg);
                div_den = PER_W'(dq_reg);
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    frdpt_div #(.NUM_W(DIV_W), .DEN_W(PER_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // round half up from remainder
    always_comb
    begin
        div_rnd = ({div_rem, 1'b0} >= {1'b0, div_den});
        quo_rnd = {1'b0, div_quo} + (DIV_W + 1)'(div_rnd);
    end

    logic [STEP_W-1:0] steps_clamp;
    logic [PER_W:0]    lim;
    logic [63:0]       adv;
    logic [PFR_W:0]    pfrac_rnd;
    logic [PER_W:0]    dper_rnd;
    logic [15:0]       corr;
    logic [63:0]       corr_num;
    logic [44:0]       corr_prod;
    logic [63:0]       t64;
    logic [SEL_W-1:0]  sel_m1;

    always_comb
    begin
        if (quo_rnd == '0)
            steps_clamp = STEP_W'(1);
        else if (quo_rnd > (DIV_W + 1)'(STEP_MAX))
            steps_clamp = STEP_MAX;
        else
            steps_clamp = quo_rnd[STEP_W-1:0];
        t64       = 64'(t_reg);
        lim       = ({1'b0, tpq_reg} << 1) >> PF;
        pfrac_rnd = ({1'b0, pfrac_reg} + (PFR_W + 1)'(HALF)) >> PF;
        adv       = 64'(pint_reg) + 64'(pfrac_rnd);
        dper_rnd  = ({1'b0, dpq_reg} + (PER_W + 1)'(HALF)) >> PF;
        // rounded err / 50 by reciprocal, saturated at the correction limit
        corr_num  = err_reg + 64'(CORR_BIAS);
        corr_prod = 45'(corr_num[21:0]) * 45'(CORR_RECIP);
        corr      = (corr_num >= CORR_SAT) ? MAX_CORR :
                    corr_prod[CORR_SHIFT+15:CORR_SHIFT];
        sel_m1    = sel_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_valid_reg <= 1'b0;
            sel_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_fin)
            begin
                ref_valid_reg <= 1'b0;
                sel_valid_reg <= 1'b0;
            end
            if (cmd.steps_one || cmd.steps_load)
                ref_valid_reg <= 1'b1;
            if (cmd.out_load)
            begin
                sel_valid_reg <= 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_rates)
        begin
            dq_reg <= disp_san;
            tq_reg <= targ_san;
        end
        if (cmd.dpq_load)
            dpq_reg <= quo_rnd[PER_W-1:0];
        if (cmd.tpq_load)
            tpq_reg <= quo_rnd[PER_W-1:0];
        if (cmd.clr_fin)
        begin
            acc_reg      <= (dq_reg > tq_reg) ? ACC_W'(dq_reg - tq_reg) : '0;
            last_ref_reg <= '0;
            last_sel_reg <= '0;
            ideal_reg    <= '0;
        end
        if (sts.in_fire)
            t_reg <= in_ch.refresh_time;
        if (cmd.steps_one || cmd.steps_load)
        begin
            steps_reg    <= cmd.steps_load ? steps_clamp : STEP_W'(1);
            last_ref_reg <= t_reg;
        end
        if (cmd.mul_acc)
            prod_reg <= ACC_W'(tq_reg * steps_reg);
        if (cmd.acc_add)
            acc_reg <= acc_reg + prod_reg;
        if (cmd.sel_load)
        begin
            sel_reg      <= div_quo[SEL_W-1:0];
            acc_reg      <= ACC_W'(div_rem);
            ival_reg     <= (sel_valid_reg && t_reg > last_sel_reg) ?
                            t_reg - last_sel_reg : '0;
            last_sel_reg <= t_reg;
        end
        if (cmd.adv_mul)
        begin
            pint_reg  <= PI_W'(tpq_reg[PER_W-1:PF] * sel_reg);
            pfrac_reg <= PFR_W'((tpq_reg[FR_W-1:0] & FMASK) * sel_reg);
        end
        if (cmd.adv_add)
            ideal_reg <= ideal_reg + adv;
        if (cmd.err_load)
        begin
            if (t64 >= ideal_reg)
            begin
                err_reg <= t64 - ideal_reg;
                neg_reg <= 1'b0;
            end
            else
            begin
                err_reg <= ideal_reg - t64;
                neg_reg <= 1'b1;
            end
        end
        if (cmd.set_ideal_t)
            ideal_reg <= t64;
        if (cmd.corr_apply)
            ideal_reg <= neg_reg ? ideal_reg - 64'(corr) : ideal_reg + 64'(corr);
        if (cmd.out_load)
        begin
            o_sel_reg  <= t_reg;
            o_ival_reg <= ival_reg;
            o_pres_reg <= TIME_W'(ideal_reg + 64'(dper_rnd));
            o_skip_reg <= (sel_m1 > SEL_W'(SKIP_MAX)) ? SKIP_MAX : SKIP_W'(sel_m1);
        end
    end

    assign in_ch.ready              = cmd.in_ready;
    assign out_ch.valid             = out_valid_reg;
    assign out_ch.selected_time     = o_sel_reg;
    assign out_ch.interval          = o_ival_reg;
    assign out_ch.presentation_time = o_pres_reg;
    assign out_ch.skipped_frames    = o_skip_reg;

    assign sts.cfg_clr   = cfg_wr && (paddr[3:2] == REG_DISPLAY_RATE ||
                                      paddr[3:2] == REG_TARGET_RATE ||
                                      paddr[3:2] == REG_ENABLE);
    assign sts.in_fire   = in_ch.valid && cmd.in_ready;
    assign sts.enable    = enable_reg;
    assign sts.need_div  = ref_valid_reg && (t_reg > last_ref_reg);
    assign sts.div_done  = div_done;
    assign sts.acc_ge    = (acc_reg >= ACC_W'(dq_reg));
    assign sts.first_sel = !sel_valid_reg;
    assign sts.big_err   = (err_reg > 64'(lim));
    assign sts.out_free  = !out_valid_reg || out_ch.ready;
endmodule

@@ hdl/frdpt_ctrl.sv @@
module frdpt_ctrl
    import frdpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);
    localparam logic [4:0] C_LOAD  = 5'd0;
    localparam logic [4:0] C_CLRD  = 5'd1;
    localparam logic [4:0] C_CLRDW = 5'd2;
    localparam logic [4:0] C_CLRT  = 5'd3;
    localparam logic [4:0] C_CLRTW = 5'd4;
    localparam logic [4:0] C_IDLE  = 5'd5;
    localparam logic [4:0] C_EN    = 5'd6;
    localparam logic [4:0] C_STW   = 5'd7;
    localparam logic [4:0] C_MUL   = 5'd8;
    localparam logic [4:0] C_ADD   = 5'd9;
    localparam logic [4:0] C_TST   = 5'd10;
    localparam logic [4:0] C_SELW  = 5'd11;
    localparam logic [4:0] C_SELD  = 5'd12;
    localparam logic [4:0] C_ADVA  = 5'd13;
    localparam logic [4:0] C_ERR   = 5'd14;
    localparam logic [4:0] C_BIG   = 5'd15;
    localparam logic [4:0] C_OUT   = 5'd17;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= C_LOAD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        cmd.div_op = DIV_DPER;
        state_next = state_reg;
        case (state_reg)
            C_LOAD:
            begin
                cmd.load_rates = 1'b1;
                state_next     = C_CLRD;
            end
            C_CLRD:
            begin
                cmd.div_start = 1'b1;
                state_next    = C_CLRDW;
            end
            C_CLRDW:
            begin
                if (sts.div_done)
                begin
                    cmd.dpq_load = 1'b1;
                    state_next   = C_CLRT;
                end
            end
            C_CLRT:
            begin
                cmd.div_op    = DIV_TPER;
                cmd.div_start = 1'b1;
                state_next    = C_CLRTW;
            end
            C_CLRTW:
            begin
                cmd.div_op = DIV_TPER;
                if (sts.div_done)
                begin
                    cmd.tpq_load = 1'b1;
                    cmd.clr_fin  = 1'b1;
                    state_next   = C_IDLE;
                end
            end
            C_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_fire)
                    state_next = C_EN;
            end
            C_EN:
            begin
                cmd.div_op = DIV_STEPS;
                if (!sts.enable)
                    state_next = C_IDLE;
                else if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = C_STW;
                end
                else
                begin
                    cmd.steps_one = 1'b1;
                    state_next    = C_MUL;
                end
            end
            C_STW:
            begin
                cmd.div_op = DIV_STEPS;
                if (sts.div_done)
                begin
                    cmd.steps_load = 1'b1;
                    state_next     = C_MUL;
                end
            end
            C_MUL:
            begin
                cmd.mul_acc = 1'b1;
                state_next  = C_ADD;
            end
            C_ADD:
            begin
                cmd.acc_add = 1'b1;
                state_next  = C_TST;
            end
            C_TST:
            begin
                cmd.div_op = DIV_SEL;
                if (sts.acc_ge)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = C_SELW;
                end
                else
                    state_next = C_IDLE;
            end
            C_SELW:
            begin
                cmd.div_op = DIV_SEL;
                if (sts.div_done)
                begin
                    cmd.sel_load = 1'b1;
                    state_next   = C_SELD;
                end
            end
            C_SELD:
            begin
                if (sts.first_sel)
                begin
                    cmd.set_ideal_t = 1'b1;
                    state_next      = C_OUT;
                end
                else
                begin
                    cmd.adv_mul = 1'b1;
                    state_next  = C_ADVA;
                end
            end
            C_ADVA:
            begin
                cmd.adv_add = 1'b1;
                state_next  = C_ERR;
            end
            C_ERR:
            begin
                cmd.err_load = 1'b1;
                state_next   = C_BIG;
            end
            C_BIG:
            begin
                if (sts.big_err)
                    cmd.set_ideal_t = 1'b1;
                else
                    cmd.corr_apply = 1'b1;
                state_next = C_OUT;
            end
            C_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_LOAD;
            end
        endcase
        // a register write restarts the state clear
        if (sts.cfg_clr)
        begin
            cmd        = '0;
            cmd.div_op = DIV_DPER;
            state_next = C_LOAD;
        end
    end
endmodule

@@ hdl/frame_rate_divider_phase_tracker_top.sv @@
// frame rate divider with phase tracking
// in_ch carries one refresh_time stamp (ns) per transaction, valid/ready handshake;
// out_ch carries selected_time, interval, presentation_time and skipped_frames for
// each refresh picked as a target frame; a refresh that is not picked gives nothing
// apb port: display_rate at 0x0, target_rate at 0x4, enable at 0x8, pready tied high
// every register write, and reset, run a state clear: two passes of the shared
// bit-serial divider of DIV_W quotient bits,
// DIV_W = max(63 + PERIOD_FRAC_BITS, 30 + PERIOD_FRAC_BITS + RATE_FRAC_BITS),
// during which in_ch.ready is low
// one transaction is in work at a time; the shared divider, one quotient bit a cycle,
// sets the cost: a dropped refresh takes at most one division, a selected one at
// most two; the phase correction divides by a constant with a reciprocal multiply
// results sit in an output register; a new refresh is taken while it waits, and a
// stalled receiver only holds the next result in its final state until out_ch.ready
module frame_rate_divider_phase_tracker_top
    import frdpt_pkg::*;
#(
    parameter int RATE_FRAC_BITS    = DEF_RATE_FRAC_BITS,
    parameter int PERIOD_FRAC_BITS  = DEF_PERIOD_FRAC_BITS,
    parameter int MAX_DISPLAY_STEPS = DEF_MAX_DISPLAY_STEPS
) (
    input  logic              clk,
    input  logic              rst_n,
    frdpt_in_if.sink          in_ch,
    frdpt_out_if.source       out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    // commands and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // no wait states on the register port
    assign pready = 1'b1;

    frdpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // datapath: rate registers, shared divider, accumulator, ideal-time tracking
    frdpt_dp #(
        .RATE_FRAC_BITS    (RATE_FRAC_BITS),
        .PERIOD_FRAC_BITS  (PERIOD_FRAC_BITS),
        .MAX_DISPLAY_STEPS (MAX_DISPLAY_STEPS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata)
    );
endmodule
